/* hdl/ozb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ozb_pkg
// Shared types, request codes and defaults for the occlusion depth buffer.
// ----------------------------------------------------------------------------
package ozb_pkg;

  // Default buffer geometry
  localparam int DEF_BUF_WIDTH  = 128;
  localparam int DEF_BUF_HEIGHT = 64;

  // Internal coordinate width: holds buffer sizes up to 2047 and any clamp sum
  localparam int COORD_W = 11;
  localparam int CNT_W   = 14;
  localparam int Z_W     = 8;

  // Request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_SPAN  = 2'd1;
  localparam logic [1:0] REQ_RECT  = 2'd2;
  localparam logic [1:0] REQ_COVER = 2'd3;

  // Far depth code written by a clear
  localparam logic [Z_W-1:0] FAR_CODE = 8'd0;

  // Saturation value of both counts
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] x_pos;
    logic [5:0] y_pos;
    logic [7:0] x_size;
    logic [6:0] y_size;
    logic [6:0] half_x;
    logic [5:0] half_y;
    logic [7:0] z_code;
  } ozb_in_t;

  typedef struct packed {
    logic              visible;
    logic [CNT_W-1:0]  visible_count;
    logic [CNT_W-1:0]  total_count;
  } ozb_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic force_clr;  // select a full clear pass
    logic load;       // capture the accepted request
    logic setup;      // compute clamped ranges, clear accumulators
    logic step;       // issue one pixel access and advance the scan
    logic emit;       // load the result register
  } ozb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;      // clamped range covers no pixel
    logic last;       // scan position is at the final pixel
  } ozb_sts_t;

endpackage
`default_nettype wire

/* hdl/occlusion_zbuffer_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// occlusion_zbuffer_engine
// Column-major 8-bit occlusion depth buffer: clear, span fill, rectangle
// visibility test and coverage count, one request at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in_*      input      in_valid / in_ready   ozb_in_t  (request)
//  out_*     output     out_valid / out_ready ozb_out_t (one result per request)
//
//  A request passes setup, a scan of the pixels in its clamped range, a drain
//  and the result load; the result becomes valid as in_ready returns for the
//  next request, and an empty range skips the scan and the drain.
//  The depth memory reads one pixel a cycle; span write-back uses its separate
//  write port in the cycle after the read.
//  A clear walks all BUF_WIDTH * BUF_HEIGHT pixels (8192 at default sizes).
//  After reset the same clearing pass runs first and in_ready stays low
//  until it ends.
//  A finished result waits in the output register; the next request is taken
//  while it waits, and only its own result stalls on out_ready.
// ----------------------------------------------------------------------------
module occlusion_zbuffer_engine #(
  parameter int BUF_WIDTH  = ozb_pkg::DEF_BUF_WIDTH,
  parameter int BUF_HEIGHT = ozb_pkg::DEF_BUF_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ozb_pkg::ozb_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ozb_pkg::ozb_out_t      out_data
);
  import ozb_pkg::*;

  ozb_cmd_t cmd;
  ozb_sts_t sts;

  // Sequencer
  ozb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Memory and arithmetic
  ozb_datapath #(
    .BUF_WIDTH  (BUF_WIDTH),
    .BUF_HEIGHT (BUF_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
`default_nettype wire

/* hdl/ozb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ozb_ctrl
// Request sequencer: reset clear pass, setup, pixel scan, drain, result hand-off.
// ----------------------------------------------------------------------------
module ozb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output ozb_pkg::ozb_cmd_t     cmd,
  input  wire ozb_pkg::ozb_sts_t sts
);
  import ozb_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one request at a time
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    boot_nxt      = boot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_INIT: begin
        cmd.force_clr = 1'b1;
        state_nxt     = ST_SETUP;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.empty ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (boot_r) begin
          boot_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ozb_ctrl: request accepted while another is in flight");

  // Never overwrite an untaken result
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("ozb_ctrl: result register overwritten");

  // The reset clear pass produces no result
  a_boot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    boot_r |-> (!out_valid_r && !in_ready))
    else $error("ozb_ctrl: activity during reset clear pass");

endmodule
`default_nettype wire

/* hdl/ozb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ozb_datapath
// Range clamping, pixel scan counters, depth memory and result accumulators.
// ----------------------------------------------------------------------------
module ozb_datapath #(
  parameter int BUF_WIDTH  = ozb_pkg::DEF_BUF_WIDTH,
  parameter int BUF_HEIGHT = ozb_pkg::DEF_BUF_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ozb_pkg::ozb_in_t   in_data,
  output ozb_pkg::ozb_out_t       out_data,
  input  wire ozb_pkg::ozb_cmd_t  cmd,
  output ozb_pkg::ozb_sts_t       sts
);
  import ozb_pkg::*;

  localparam int XW        = (BUF_WIDTH  > 1) ? $clog2(BUF_WIDTH)  : 1;
  localparam int YW        = (BUF_HEIGHT > 1) ? $clog2(BUF_HEIGHT) : 1;
  localparam int AW        = XW + YW;
  localparam int MEM_DEPTH = BUF_WIDTH * (2 ** YW);

  localparam logic [COORD_W-1:0] W_C = COORD_W'(BUF_WIDTH);
  localparam logic [COORD_W-1:0] H_C = COORD_W'(BUF_HEIGHT);

  // Request and scan registers
  ozb_in_t            req_r;
  logic [1:0]         op_r;
  logic [COORD_W-1:0] x_hi_r, y_lo_r, y_hi_r;
  logic [COORD_W-1:0] cur_x_r, cur_y_r;

  // Access pipeline and accumulators
  logic               p_valid_r;
  logic [AW-1:0]      p_addr_r;
  logic [Z_W-1:0]     rd_data_r;
  logic               any_r;
  logic [CNT_W-1:0]   vis_cnt_r, tot_cnt_r;
  ozb_out_t           out_data_r;

  logic [Z_W-1:0]     mem [MEM_DEPTH];

  // Range calculation signals
  logic [COORD_W-1:0] px, py, sx, sy, hx, hy;
  logic [COORD_W-1:0] x_sum, y_sum, xh_sum, yh_sum;
  logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic               empty;

  logic [AW-1:0]      rd_addr;
  logic               clr_we, span_we, mem_we, hit;
  logic [AW-1:0]      wr_addr;
  logic [Z_W-1:0]     wr_data;

  // Clamp the request to the buffer
  always_comb begin
    px     = COORD_W'(req_r.x_pos);
    py     = COORD_W'(req_r.y_pos);
    sx     = COORD_W'(req_r.x_size);
    sy     = COORD_W'(req_r.y_size);
    hx     = COORD_W'(req_r.half_x);
    hy     = COORD_W'(req_r.half_y);
    x_sum  = px + sx;
    y_sum  = py + sy;
    xh_sum = px + hx;
    yh_sum = py + hy;
    x_lo   = '0;
    x_hi   = W_C - 1'b1;
    y_lo   = '0;
    y_hi   = H_C - 1'b1;
    empty  = 1'b0;
    unique case (op_r)
      REQ_CLEAR: begin
        empty = 1'b0;
      end
      REQ_SPAN: begin
        x_lo  = px;
        x_hi  = px;
        y_lo  = py;
        y_hi  = ((y_sum > H_C) ? H_C : y_sum) - 1'b1;
        empty = (px >= W_C) || (py >= H_C) || (sy == '0);
      end
      REQ_RECT: begin
        x_lo  = px;
        x_hi  = ((x_sum > W_C) ? W_C : x_sum) - 1'b1;
        y_lo  = py;
        y_hi  = ((y_sum > H_C) ? H_C : y_sum) - 1'b1;
        empty = (px >= W_C) || (py >= H_C) || (sx == '0) || (sy == '0);
      end
      REQ_COVER: begin
        x_lo  = (px >= hx) ? (px - hx) : '0;
        x_hi  = (xh_sum > W_C - 1'b1) ? (W_C - 1'b1) : xh_sum;
        y_lo  = (py >= hy) ? (py - hy) : '0;
        y_hi  = (yh_sum > H_C - 1'b1) ? (H_C - 1'b1) : yh_sum;
        empty = (x_lo > x_hi) || (y_lo > y_hi);
      end
      default: begin
        empty = 1'b1;
      end
    endcase
  end

  assign sts.empty = empty;
  assign sts.last  = (cur_x_r == x_hi_r) && (cur_y_r == y_hi_r);

  // Pixel address, column major
  assign rd_addr = {cur_x_r[XW-1:0], cur_y_r[YW-1:0]};
  assign hit     = (rd_data_r <= req_r.z_code);

  // Write port: clear pass writes at the scan address, span writes in the cycle after its read
  assign clr_we  = cmd.step && (op_r == REQ_CLEAR);
  assign span_we = p_valid_r && (op_r == REQ_SPAN) && (rd_data_r < req_r.z_code);
  assign mem_we  = clr_we || span_we;
  assign wr_addr = clr_we ? rd_addr : p_addr_r;
  assign wr_data = clr_we ? FAR_CODE : req_r.z_code;

  // Depth memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Capture request, load ranges, advance the scan
  always_ff @(posedge clk) begin
    if (cmd.force_clr) begin
      op_r <= REQ_CLEAR;
    end else if (cmd.load) begin
      req_r <= in_data;
      op_r  <= in_data.req_type;
    end
    if (cmd.setup) begin
      x_hi_r  <= x_hi;
      y_lo_r  <= y_lo;
      y_hi_r  <= y_hi;
      cur_x_r <= x_lo;
      cur_y_r <= y_lo;
    end else if (cmd.step) begin
      if (cur_y_r == y_hi_r) begin
        cur_y_r <= y_lo_r;
        cur_x_r <= cur_x_r + 1'b1;
      end else begin
        cur_y_r <= cur_y_r + 1'b1;
      end
    end
    p_addr_r <= rd_addr;
  end

  // Track which cycle carries read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.step;
    end
  end

  // Accumulate hits and saturating counts
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      any_r     <= 1'b0;
      vis_cnt_r <= '0;
      tot_cnt_r <= '0;
    end else if (p_valid_r) begin
      any_r <= any_r | hit;
      if (op_r == REQ_COVER) begin
        if (tot_cnt_r != CNT_MAX) begin
          tot_cnt_r <= tot_cnt_r + 1'b1;
        end
        if (hit && (vis_cnt_r != CNT_MAX)) begin
          vis_cnt_r <= vis_cnt_r + 1'b1;
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.visible       <= ((op_r == REQ_RECT) || (op_r == REQ_COVER)) && any_r;
      out_data_r.visible_count <= (op_r == REQ_COVER) ? vis_cnt_r : '0;
      out_data_r.total_count   <= (op_r == REQ_COVER) ? tot_cnt_r : '0;
    end
  end

  assign out_data = out_data_r;

  // Tests never modify the buffer
  a_write_op: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((op_r == REQ_CLEAR) || (op_r == REQ_SPAN)))
    else $error("ozb_datapath: memory write during a read-only request");

  // Span write-back never collides with the read issued in the same cycle
  a_rmw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (span_we && cmd.step) |-> (p_addr_r != rd_addr))
    else $error("ozb_datapath: span write and read at the same pixel");

  // Visible pixels never outnumber counted pixels
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (tot_cnt_r >= vis_cnt_r))
    else $error("ozb_datapath: visible count exceeds total count");

endmodule
`default_nettype wire
